### hw/rtl/pd_steer_differential_drive_unit_defines.svh
// Assertion macros shared by the steering unit RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef PD_STEER_DIFFERENTIAL_DRIVE_UNIT_DEFINES_SVH
`define PD_STEER_DIFFERENTIAL_DRIVE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define PD_ASSERT(label, prop)
`define PD_ASSERT_ALWAYS(label, prop)
`endif

`endif

### hw/rtl/pdsdd_pkg.sv
// Package for the PD steering unit: register indexes, reset values, codes and types.
// No dependencies.
package pdsdd_pkg;

    localparam int PROP_GAIN_W   = 16;
    localparam int DERIV_GAIN_W  = 18;
    localparam int SPEED_LIMIT_W = 8;
    localparam int CFG_DATA_W    = 18;
    localparam int CFG_INDEX_W   = 2;
    localparam int SENSE_W       = 10;
    localparam int DUTY_W        = 8;
    localparam int FRAC_BITS     = 16;
    localparam int DUTY_MAX      = 255;
    localparam int CUTOFF_INIT   = 1000;

    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT = 2'd2;

    localparam logic [PROP_GAIN_W-1:0]   PROP_GAIN_RST   = 16'd6554;
    localparam logic [DERIV_GAIN_W-1:0]  DERIV_GAIN_RST  = 18'd65536;
    localparam logic [SPEED_LIMIT_W-1:0] SPEED_LIMIT_RST = 8'd190;

    localparam logic [1:0] QUAD_TOP_RIGHT = 2'd0;
    localparam logic [1:0] QUAD_TOP_LEFT  = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULP,
        S_MULD,
        S_TURN,
        S_MULL,
        S_DIVS,
        S_DIVW,
        S_MIX
    } pdsdd_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### hw/rtl/pdsdd_div.sv
// Bit-serial signed-by-unsigned divider, quotient truncated toward zero.
// Depends on pdsdd_pkg and the assertion macro header.
`include "pd_steer_differential_drive_unit_defines.svh"

module pdsdd_div import pdsdd_pkg::*; #(
    parameter int NW = 19,
    parameter int DW = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic        [DW-1:0] den,
    output div_stat_t            stat,
    output logic signed [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic                 busy_reg;
    logic                 fin_reg;
    logic                 done_reg;
    logic        [CW-1:0] cnt_reg;
    logic                 neg_reg;
    logic        [NW-1:0] mag_reg;
    logic        [DW-1:0] rem_reg;
    logic        [DW-1:0] den_reg;
    logic signed [NW-1:0] quo_reg;

    logic [DW:0]   shifted;
    logic [DW+1:0] trial;
    logic          take;

    assign shifted = {rem_reg, mag_reg[NW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign take    = !trial[DW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NW-1];
            mag_reg <= num[NW-1] ? (~num + 1'b1) : num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? trial[DW-1:0] : shifted[DW-1:0];
            mag_reg <= {mag_reg[NW-2:0], take};
        end
        else if (fin_reg)
        begin
            quo_reg <= neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
        end
    end

    assign stat.busy = busy_reg | fin_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

    `PD_ASSERT(a_div_start_idle, start |-> !stat.busy)
    `PD_ASSERT(a_div_start_busy, start |=> stat.busy)
    `PD_ASSERT(a_div_done_pulse, stat.done |=> !stat.done)

endmodule

### hw/rtl/pd_steer_differential_drive_unit.sv
// PD steering and differential drive mixer, top level.
// Depends on pdsdd_pkg, pdsdd_div and the assertion macro header.
//
//  channel   handshake               payload
//  input     in_valid / in_ready     angle_est, quadrant, sense_* (4)
//  output    out_valid / out_ready   left_duty, left_forward, right_duty, right_forward
//  config    cfg_we                  cfg_index, cfg_data
//
// Each request steps through the states MULP, MULD and TURN to MIX; when a speed division
// is made, MULL, DIVS and DIVW come between, and the bit-serial divider works out one
// quotient bit per cycle. One shared multiplier forms both PD products and the speed numerator.
// Reset clears the gains to their defaults, the history and the sequencer.
// A new request is taken while the previous result waits; the mix step holds
// until the output register is free.
`include "pd_steer_differential_drive_unit_defines.svh"

module pd_steer_differential_drive_unit import pdsdd_pkg::*; #(
    parameter int ANGLE_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [ANGLE_BITS-1:0]  angle_est,
    input  logic [1:0]                    quadrant,
    input  logic [SENSE_W-1:0]            sense_top_left,
    input  logic [SENSE_W-1:0]            sense_top_right,
    input  logic [SENSE_W-1:0]            sense_bottom_left,
    input  logic [SENSE_W-1:0]            sense_bottom_right,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [DUTY_W-1:0]             left_duty,
    output logic                          left_forward,
    output logic [DUTY_W-1:0]             right_duty,
    output logic                          right_forward
);

    localparam int A     = ANGLE_BITS;
    localparam int YW    = A + 2;
    localparam int PW    = DERIV_GAIN_W + 1 + YW;
    localparam int ACCW  = PW + 1;
    localparam int TW    = ACCW - FRAC_BITS;
    localparam int NUMW  = A + 9;
    localparam int MW    = A + 11;
    localparam int TOP_I = (1 << (A - 1)) - 1;
    localparam int CUT_I = (TOP_I < CUTOFF_INIT) ? TOP_I : CUTOFF_INIT;
    localparam logic signed [A-1:0] CUT_START = A'(CUT_I);

    pdsdd_state_t state_reg, state_next;

    logic [PROP_GAIN_W-1:0]   prop_gain_reg;
    logic [DERIV_GAIN_W-1:0]  deriv_gain_reg;
    logic [SPEED_LIMIT_W-1:0] speed_limit_reg;

    logic                started_reg;
    logic signed [A-1:0] prev_reg;
    logic signed [A-1:0] cutoff_reg;

    logic signed [A-1:0]    a_reg;
    logic signed [A:0]      diff_reg;
    logic        [A-1:0]    c_reg;
    logic [1:0]             quad_reg;
    logic                   go_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [TW-1:0]   turn_reg;
    logic signed [NUMW-1:0] num_reg;
    logic signed [MW-1:0]   spd_reg;

    logic                out_valid_reg;
    logic [DUTY_W-1:0]   left_duty_reg;
    logic                left_fwd_reg;
    logic [DUTY_W-1:0]   right_duty_reg;
    logic                right_fwd_reg;

    logic signed [A-1:0]  prev_eff;
    logic signed [A-1:0]  cut_eff;
    logic                 top_quad;
    logic                 cmp_ok;

    logic [DERIV_GAIN_W-1:0] mul_x;
    logic signed [YW-1:0]    mul_y;
    logic signed [PW-1:0]    prod;
    logic signed [YW-1:0]    c_ext;
    logic signed [YW-1:0]    a_ext;
    logic signed [ACCW-1:0]  acc_rnd;

    logic signed [MW-1:0] turn_ext;
    logic signed [MW-1:0] turn_abs;
    logic signed [MW-1:0] room;
    logic signed [MW-1:0] spd_cap;
    logic signed [MW-1:0] left_dem;
    logic signed [MW-1:0] right_dem;
    logic [DUTY_W:0]      left_drv;
    logic [DUTY_W:0]      right_drv;
    logic                 mix_go;

    logic                   div_start;
    div_stat_t              div_stat;
    logic signed [NUMW-1:0] div_quo;

    function automatic logic [DUTY_W:0] drive(input logic signed [MW-1:0] d);
        logic signed [MW-1:0] pos_max;
        logic signed [MW-1:0] neg_d;
        pos_max = $signed(MW'(DUTY_MAX));
        neg_d   = -d;
        if (d > pos_max)
            drive = {1'b1, DUTY_W'(DUTY_MAX)};
        else if (d < -pos_max)
            drive = {1'b0, DUTY_W'(DUTY_MAX)};
        else if (d < 0)
            drive = {1'b0, neg_d[DUTY_W-1:0]};
        else
            drive = {1'b1, d[DUTY_W-1:0]};
    endfunction

    // request capture
    assign prev_eff = started_reg ? prev_reg : angle_est;
    assign cut_eff  = started_reg ? cutoff_reg : CUT_START;
    assign top_quad = quadrant inside {QUAD_TOP_RIGHT, QUAD_TOP_LEFT};
    assign cmp_ok   = (quadrant == QUAD_TOP_RIGHT) ? (sense_top_left > sense_bottom_right)
                                                   : (sense_top_right > sense_bottom_left);

    // shared multiplier
    assign c_ext = $signed({2'b00, c_reg});
    assign a_ext = $signed({{2{a_reg[A-1]}}, a_reg});

    always_comb
    begin
        case (state_reg)
            S_MULP:
            begin
                mul_x = DERIV_GAIN_W'(prop_gain_reg);
                mul_y = a_ext;
            end
            S_MULD:
            begin
                mul_x = deriv_gain_reg;
                mul_y = $signed({diff_reg[A], diff_reg});
            end
            default:
            begin
                mul_x = DERIV_GAIN_W'(speed_limit_reg);
                mul_y = (quad_reg == QUAD_TOP_RIGHT) ? (c_ext - a_ext) : (c_ext + a_ext);
            end
        endcase
    end

    assign prod    = $signed({1'b0, mul_x}) * mul_y;
    assign acc_rnd = acc_reg + (acc_reg[ACCW-1] ? ACCW'((1 << FRAC_BITS) - 1) : ACCW'(0));

    // cap and mix
    assign turn_ext  = MW'(turn_reg);
    assign turn_abs  = turn_reg[TW-1] ? -turn_ext : turn_ext;
    assign room      = $signed(MW'(speed_limit_reg)) - turn_abs;
    assign spd_cap   = (spd_reg > room) ? room : spd_reg;
    assign left_dem  = spd_cap + turn_ext;
    assign right_dem = spd_cap - turn_ext;
    assign left_drv  = drive(left_dem);
    assign right_drv = drive(right_dem);
    assign mix_go    = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = S_MULP;
            end
            S_MULP: state_next = S_MULD;
            S_MULD: state_next = S_TURN;
            S_TURN: state_next = go_reg ? S_MULL : S_MIX;
            S_MULL: state_next = S_DIVS;
            S_DIVS:
            begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_stat.done)
                    state_next = S_MIX;
            end
            S_MIX:
            begin
                if (mix_go)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // configuration and loop history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= PROP_GAIN_RST;
            deriv_gain_reg  <= DERIV_GAIN_RST;
            speed_limit_reg <= SPEED_LIMIT_RST;
            started_reg     <= 1'b0;
            prev_reg        <= '0;
            cutoff_reg      <= CUT_START;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:   prop_gain_reg   <= cfg_data[PROP_GAIN_W-1:0];
                    REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data[DERIV_GAIN_W-1:0];
                    REG_SPEED_LIMIT: speed_limit_reg <= cfg_data[SPEED_LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                started_reg <= 1'b1;
                prev_reg    <= angle_est;
                cutoff_reg  <= (top_quad && !cmp_ok) ? angle_est : cut_eff;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_reg    <= angle_est;
                    diff_reg <= $signed({angle_est[A-1], angle_est})
                                - $signed({prev_eff[A-1], prev_eff});
                    c_reg    <= cut_eff[A-1] ? (~cut_eff + 1'b1) : cut_eff;
                    quad_reg <= quadrant;
                    go_reg   <= top_quad && cmp_ok && (cut_eff != '0);
                end
            end
            S_MULP: acc_reg <= ACCW'(prod);
            S_MULD: acc_reg <= acc_reg + ACCW'(prod);
            S_TURN:
            begin
                turn_reg <= acc_rnd[ACCW-1:FRAC_BITS];
                spd_reg  <= '0;
            end
            S_MULL: num_reg <= prod[NUMW-1:0];
            S_DIVW:
            begin
                if (div_stat.done)
                    spd_reg <= MW'(div_quo);
            end
            S_MIX:
            begin
                if (mix_go)
                begin
                    left_fwd_reg   <= left_drv[DUTY_W];
                    left_duty_reg  <= left_drv[DUTY_W-1:0];
                    right_fwd_reg  <= right_drv[DUTY_W];
                    right_duty_reg <= right_drv[DUTY_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_MIX && mix_go)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    pdsdd_div #(
        .NW (NUMW),
        .DW (A)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (c_reg),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    assign out_valid     = out_valid_reg;
    assign left_duty     = left_duty_reg;
    assign left_forward  = left_fwd_reg;
    assign right_duty    = right_duty_reg;
    assign right_forward = right_fwd_reg;

    `PD_ASSERT(a_accept_then_busy, in_valid && in_ready |=> !in_ready)
    `PD_ASSERT(a_result_from_mix, $rose(out_valid) |-> $past(state_reg == S_MIX))
    `PD_ASSERT(a_started_sticks, started_reg |=> started_reg)
    `PD_ASSERT(a_mix_holds, state_reg == S_MIX && out_valid && !out_ready |=> state_reg == S_MIX)

endmodule

### tb/pd_steer_differential_drive_unit_tb.sv
// Self-checking testbench for pd_steer_differential_drive_unit: directed rows, then
// fixed and randomized register settings with random requests, checked against an
// in-bench steering model. Depends on pdsdd_pkg and the unit RTL only.
module pd_steer_differential_drive_unit_tb import pdsdd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_W = 10;
    localparam int ANGLE_TOP = 2 ** (ANGLE_W - 1) - 1;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W - 1){1'b1}}};
    localparam logic [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W - 1){1'b0}}};
    localparam logic [ANGLE_W-1:0] CUTOFF_START =
        ANGLE_W'((ANGLE_TOP < CUTOFF_INIT) ? ANGLE_TOP : CUTOFF_INIT);
    localparam logic [SENSE_W-1:0] SENSE_MAX = {SENSE_W{1'b1}};
    localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_AFTER = 380;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [1:0]         quad;
        logic [SENSE_W-1:0] tl;
        logic [SENSE_W-1:0] tr;
        logic [SENSE_W-1:0] bl;
        logic [SENSE_W-1:0] br;
    } steer_req_t;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic              left_forward;
        logic [DUTY_W-1:0] right_duty;
        logic              right_forward;
    } wheel_cmd_t;

    typedef struct packed {
        steer_req_t req;
        bit         typed;
        wheel_cmd_t cmd;
    } steer_row_t;

    typedef struct packed {
        bit                    rand_cfg;
        logic [CFG_DATA_W-1:0] pg;
        logic [CFG_DATA_W-1:0] dg;
        logic [CFG_DATA_W-1:0] sl;
        bit                    idle;
        int unsigned           count;
    } phase_t;

    // typed rows hold the expected wheel command; the rest go through the model
    localparam int N_ROWS = 21;
    localparam steer_row_t DIRECTED_ROWS [N_ROWS] = '{
        // first request after reset, bottom quadrant
        '{'{10'd0, 2'd2, 10'd0, 10'd0, 10'd0, 10'd0}, 1'b1, '{8'd0, 1'b1, 8'd0, 1'b1}},
        '{'{10'd0, 2'd0, SENSE_MAX, 10'd0, 10'd0, 10'd0}, 1'b1,
          '{8'd190, 1'b1, 8'd190, 1'b1}},
        '{'{ANGLE_MAX, 2'd0, SENSE_MAX, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
        '{'{ANGLE_MIN, 2'd1, 10'd0, SENSE_MAX, 10'd0, SENSE_MAX}, 1'b0, '0},
        // failed comparison loads the cutoff
        '{'{ANGLE_MIN, 2'd0, 10'd0, 10'd0, 10'd0, SENSE_MAX}, 1'b0, '0},
        '{'{10'sd100, 2'd0, SENSE_MAX, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
        '{'{-10'sd100, 2'd1, 10'd0, 10'd700, 10'd700, 10'd0}, 1'b0, '0},
        '{'{10'd0, 2'd0, 10'd300, 10'd0, 10'd0, 10'd300}, 1'b0, '0},
        // zero cutoff
        '{'{10'd0, 2'd0, SENSE_MAX, 10'd0, 10'd0, 10'd0}, 1'b1, '{8'd0, 1'b1, 8'd0, 1'b1}},
        '{'{10'sd50, 2'd1, 10'd0, SENSE_MAX, 10'd0, 10'd0}, 1'b0, '0},
        '{'{10'sd1, 2'd1, 10'd0, 10'd0, SENSE_MAX, 10'd0}, 1'b0, '0},
        // large negative speed, both sides saturate in reverse
        '{'{ANGLE_MAX, 2'd0, SENSE_MAX, 10'd0, 10'd0, 10'd0}, 1'b1,
          '{8'd255, 1'b0, 8'd255, 1'b0}},
        '{'{-10'sd1, 2'd3, SENSE_MAX, SENSE_MAX, SENSE_MAX, SENSE_MAX}, 1'b0, '0},
        '{'{ANGLE_MIN, 2'd2, SENSE_MAX, SENSE_MAX, SENSE_MAX, SENSE_MAX}, 1'b0, '0},
        '{'{ANGLE_MAX, 2'd3, 10'h2AA, 10'h155, 10'h155, 10'h2AA}, 1'b0, '0},
        '{'{10'd0, 2'd1, 10'h155, SENSE_MAX, 10'd1022, 10'h2AA}, 1'b0, '0},
        '{'{-10'sd1, 2'd1, 10'd0, 10'd1, 10'd0, 10'd0}, 1'b0, '0},
        '{'{10'sd2, 2'd0, 10'd1, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
        '{'{ANGLE_MIN, 2'd0, 10'd0, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
        '{'{ANGLE_MIN, 2'd0, SENSE_MAX, 10'd0, 10'd0, 10'd1022}, 1'b0, '0},
        '{'{ANGLE_MAX, 2'd1, 10'd0, SENSE_MAX, 10'd0, 10'd0}, 1'b0, '0}
    };

    localparam int N_PHASES = 8;
    localparam phase_t PHASES [N_PHASES] = '{
        '{1'b0, 18'd0, 18'd0, 18'd0, 1'b1, 150},
        '{1'b0, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 1'b1, 180},
        '{1'b0, 18'd6554, 18'd65536, 18'd190, 1'b0, 180},
        '{1'b1, 18'd0, 18'd0, 18'd0, 1'b1, 200},
        '{1'b0, 18'd65535, 18'd0, 18'd255, 1'b1, 180},
        '{1'b0, 18'd0, 18'd131072, 18'd1, 1'b1, 180},
        '{1'b1, 18'd0, 18'd0, 18'd0, 1'b1, 200},
        '{1'b1, 18'd0, 18'd0, 18'd0, 1'b0, 180}
    };

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [CFG_INDEX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    logic signed [ANGLE_W-1:0]    angle_est;
    logic [1:0]                   quadrant;
    logic [SENSE_W-1:0]           sense_top_left;
    logic [SENSE_W-1:0]           sense_top_right;
    logic [SENSE_W-1:0]           sense_bottom_left;
    logic [SENSE_W-1:0]           sense_bottom_right;
    logic                         out_valid;
    logic                         out_ready;
    logic [DUTY_W-1:0]            left_duty;
    logic                         left_forward;
    logic [DUTY_W-1:0]            right_duty;
    logic                         right_forward;

    // steering model state and register copies
    bit                      steer_started;
    logic [ANGLE_W-1:0]      last_bearing;
    logic [ANGLE_W-1:0]      bearing_cutoff;
    logic [PROP_GAIN_W-1:0]  kp;
    logic [DERIV_GAIN_W-1:0] kd;
    logic [SPEED_LIMIT_W-1:0] top_speed;

    wheel_cmd_t wheel_cmd_q [$];
    bit          idle_en;
    int          error_count;
    int          requests_sent;
    int          results_checked;
    int          settings_applied;
    int          cycle_count;

    pd_steer_differential_drive_unit #(
        .ANGLE_BITS(ANGLE_W)
    ) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .angle_est         (angle_est),
        .quadrant          (quadrant),
        .sense_top_left    (sense_top_left),
        .sense_top_right   (sense_top_right),
        .sense_bottom_left (sense_bottom_left),
        .sense_bottom_right(sense_bottom_right),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .left_duty         (left_duty),
        .left_forward      (left_forward),
        .right_duty        (right_duty),
        .right_forward     (right_forward)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [DUTY_W:0] to_pwm(longint demand);
        if (demand > DUTY_MAX)
            return {1'b1, DUTY_W'(DUTY_MAX)};
        else if (demand < -DUTY_MAX)
            return {1'b0, DUTY_W'(DUTY_MAX)};
        else if (demand < 0)
            return {1'b0, DUTY_W'(-demand)};
        return {1'b1, DUTY_W'(demand)};
    endfunction

    // advances the model state by one request
    function automatic wheel_cmd_t steer_predict(steer_req_t r);
        longint bearing;
        longint turn;
        longint speed;
        longint cut_mag;
        longint room;
        longint lim;
        wheel_cmd_t cmd;
        bearing = longint'($signed(r.angle));
        lim = longint'(top_speed);
        if (!steer_started)
        begin
            last_bearing = r.angle;
            bearing_cutoff = CUTOFF_START;
            steer_started = 1'b1;
        end
        turn = (longint'(kp) * bearing
                + longint'(kd) * (bearing - longint'($signed(last_bearing))))
               / (longint'(1) << FRAC_BITS);
        last_bearing = r.angle;
        speed = 0;
        cut_mag = longint'($signed(bearing_cutoff));
        if (cut_mag < 0)
            cut_mag = -cut_mag;
        case (r.quad)
            QUAD_TOP_RIGHT:
            begin
                if (r.tl > r.br)
                begin
                    if (cut_mag != 0)
                        speed = (lim * cut_mag - lim * bearing) / cut_mag;
                end
                else
                    bearing_cutoff = r.angle;
            end
            QUAD_TOP_LEFT:
            begin
                if (r.tr > r.bl)
                begin
                    if (cut_mag != 0)
                        speed = (lim * cut_mag + lim * bearing) / cut_mag;
                end
                else
                    bearing_cutoff = r.angle;
            end
            default: ;
        endcase
        room = lim - ((turn < 0) ? -turn : turn);
        if (speed > room)
            speed = room;
        {cmd.left_forward, cmd.left_duty} = to_pwm(speed + turn);
        {cmd.right_forward, cmd.right_duty} = to_pwm(speed - turn);
        return cmd;
    endfunction

    task automatic offer(input steer_req_t req, input bit typed, input wheel_cmd_t typed_cmd);
        wheel_cmd_t predicted;
        int gap;
        in_valid <= 1'b1;
        angle_est <= req.angle;
        quadrant <= req.quad;
        sense_top_left <= req.tl;
        sense_top_right <= req.tr;
        sense_bottom_left <= req.bl;
        sense_bottom_right <= req.br;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = steer_predict(req);
        wheel_cmd_q.push_back(typed ? typed_cmd : predicted);
        requests_sent++;
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // block must be idle before any register write
    task automatic settle();
        in_valid <= 1'b0;
        while (wheel_cmd_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] pg,
                                  input logic [CFG_DATA_W-1:0] dg,
                                  input logic [CFG_DATA_W-1:0] sl);
        logic [CFG_INDEX_W-1:0] reg_ids [4];
        logic [CFG_DATA_W-1:0] vals [4];
        reg_ids = '{REG_PROP_GAIN, REG_DERIV_GAIN, REG_SPEED_LIMIT, REG_NONE};
        vals = '{pg, dg, sl, CFG_DATA_W'($urandom)};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= reg_ids[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        kp = pg[PROP_GAIN_W-1:0];
        kd = dg[DERIV_GAIN_W-1:0];
        top_speed = sl[SPEED_LIMIT_W-1:0];
        settings_applied++;
    endtask

    always @(posedge clk)
    begin
        wheel_cmd_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (wheel_cmd_q.size() == 0)
            begin
                error_count++;
                $error("unexpected result: left %0d/%0d right %0d/%0d",
                       left_duty, left_forward, right_duty, right_forward);
            end
            else
            begin
                want = wheel_cmd_q.pop_front();
                if (left_duty !== want.left_duty)
                begin
                    error_count++;
                    $error("left_duty: expected %0d, got %0d", want.left_duty, left_duty);
                end
                if (left_forward !== want.left_forward)
                begin
                    error_count++;
                    $error("left_forward: expected %0d, got %0d",
                           want.left_forward, left_forward);
                end
                if (right_duty !== want.right_duty)
                begin
                    error_count++;
                    $error("right_duty: expected %0d, got %0d", want.right_duty, right_duty);
                end
                if (right_forward !== want.right_forward)
                begin
                    error_count++;
                    $error("right_forward: expected %0d, got %0d",
                           want.right_forward, right_forward);
                end
            end
        end
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        int stall_left;
        int rx_count;
        bit held;
        stall_left = 0;
        rx_count = 0;
        held = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                rx_count++;
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!held && rx_count >= HOLD_AFTER)
            begin
                held = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("pd_steer_differential_drive_unit verification failed");
        $finish;
    end

    initial
    begin
        steer_req_t req;
        int sel;
        int q_pick;
        logic [CFG_DATA_W-1:0] pg;
        logic [CFG_DATA_W-1:0] dg;
        logic [CFG_DATA_W-1:0] sl;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        angle_est = '0;
        quadrant = '0;
        sense_top_left = '0;
        sense_top_right = '0;
        sense_bottom_left = '0;
        sense_bottom_right = '0;
        steer_started = 1'b0;
        last_bearing = '0;
        bearing_cutoff = CUTOFF_START;
        kp = PROP_GAIN_RST;
        kd = DERIV_GAIN_RST;
        top_speed = SPEED_LIMIT_RST;
        idle_en = 1'b1;
        error_count = 0;
        requests_sent = 0;
        results_checked = 0;
        settings_applied = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
            offer(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].cmd);
        settle();

        for (int p = 0; p < N_PHASES; p++)
        begin
            pg = PHASES[p].pg;
            dg = PHASES[p].dg;
            sl = PHASES[p].sl;
            if (PHASES[p].rand_cfg)
            begin
                pg = CFG_DATA_W'($urandom_range(0, 65535));
                dg = CFG_DATA_W'($urandom_range(0, 2 ** DERIV_GAIN_W - 1));
                sl = CFG_DATA_W'($urandom_range(0, 255));
            end
            apply_settings(pg, dg, sl);
            idle_en = PHASES[p].idle;
            for (int unsigned n = 0; n < PHASES[p].count; n++)
            begin
                sel = $urandom_range(0, 9);
                case (sel)
                    0: req.angle = ANGLE_MAX;
                    1: req.angle = ANGLE_MIN;
                    2: req.angle = '0;
                    3: req.angle = ANGLE_W'($urandom_range(0, 6)) - ANGLE_W'(3);
                    default: req.angle = ANGLE_W'($urandom);
                endcase
                q_pick = $urandom_range(0, 5);
                req.quad = (q_pick > 3) ? 2'(q_pick - 4) : 2'(q_pick);
                req.tl = SENSE_W'($urandom);
                req.tr = SENSE_W'($urandom);
                req.bl = SENSE_W'($urandom);
                req.br = SENSE_W'($urandom);
                // ties fail the sensor comparison
                if ($urandom_range(0, 7) == 0)
                begin
                    req.br = req.tl;
                    req.bl = req.tr;
                end
                offer(req, 1'b0, '0);
            end
            settle();
        end

        $display("Covered %0d steering requests (%0d table rows) over %0d register settings,",
                 requests_sent, N_ROWS, settings_applied);
        $display("%0d results compared; output held off %0d cycles once to back up the input.",
                 results_checked, HOLD_CYCLES);
        if (error_count == 0)
            $display("pd_steer_differential_drive_unit verification clean");
        else
            $display("pd_steer_differential_drive_unit verification failed");
        $finish;
    end

endmodule
